[design/assert_macros.svh]
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge; hold off while reset is low.
`define SSD_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ssd assertion failed");

// Same check on the default clock and reset of the design.
`define SSD_ASSERT(lbl, prop) \
  `SSD_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

[design/ssd_pkg.sv]
// Types, constants and the digit encoder of the two-wire display driver.
package ssd_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned FrameMax   = DigitCount + 1;
  localparam int unsigned FrameIdxW  = $clog2(FrameMax);

  localparam logic [7:0] CmdAutoInc   = 8'h40;
  localparam logic [7:0] CmdAddrZero  = 8'hC0;
  localparam logic [7:0] CmdDispOff   = 8'h80;
  localparam logic [7:0] CmdDispOn    = 8'h88;
  localparam logic [7:0] ColonBit     = 8'h80;
  localparam logic [7:0] MaxBright    = 8'd8;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_DIGITS = 2'd1,
    MODE_RAW    = 2'd2,
    MODE_BRIGHT = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_S0   = 4'd1,
    PH_S1   = 4'd2,
    PH_B0   = 4'd3,
    PH_B1   = 4'd4,
    PH_A0   = 4'd5,
    PH_A1   = 4'd6,
    PH_P0   = 4'd7,
    PH_P1   = 4'd8,
    PH_P2   = 4'd9,
    PH_P3   = 4'd10
  } bus_phase_e;

  typedef logic [FrameMax-1:0][7:0] frame_t;

  // Frame contents and sequencing of one accepted request.
  typedef struct packed {
    frame_t     frame;
    logic [2:0] len;
    logic       two_frames;
  } frame_req_t;

  // Map an ASCII digit to its segment pattern; anything else is blank.
  function automatic logic [7:0] seg_code(input logic [7:0] ch);
    logic [7:0] s;
    unique case (ch)
      8'h30:   s = 8'h3f;
      8'h31:   s = 8'h06;
      8'h32:   s = 8'h5b;
      8'h33:   s = 8'h4f;
      8'h34:   s = 8'h66;
      8'h35:   s = 8'h6d;
      8'h36:   s = 8'h7d;
      8'h37:   s = 8'h07;
      8'h38:   s = 8'h7f;
      8'h39:   s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[design/ssd_frame_build.sv]
// Builds the frame bytes and frame sequencing for one display or brightness request.
module ssd_frame_build import ssd_pkg::*; (
  input  mode_e      mode_i,
  input  logic [7:0] byte0_i,
  input  logic [7:0] byte1_i,
  input  logic [7:0] byte2_i,
  input  logic [7:0] byte3_i,
  input  logic       colon_on_i,
  output frame_req_t req_o
);

  logic [3:0][7:0] chars;
  logic [7:0]      level;

  assign chars = {byte3_i, byte2_i, byte1_i, byte0_i};

  always_comb begin
    level     = byte0_i;
    req_o     = '0;
    if (mode_i == MODE_BRIGHT) begin
      // Clamp to the top step; zero turns the display off.
      if (level > MaxBright) begin
        level = MaxBright;
      end
      if (byte0_i == 8'd0) begin
        req_o.frame[0] = CmdDispOff;
      end else begin
        req_o.frame[0] = CmdDispOn | {5'd0, 3'(level - 8'd1)};
      end
      req_o.len        = 3'd1;
      req_o.two_frames = 1'b0;
    end else begin
      req_o.frame[0] = CmdAddrZero;
      for (int i = 0; i < DigitCount; i++) begin
        if (i < 4) begin
          if (mode_i == MODE_RAW) begin
            req_o.frame[i+1] = chars[2'(i)];
          end else begin
            req_o.frame[i+1] = seg_code(chars[2'(i)]);
            if (i == 1) begin
              req_o.frame[i+1][7] = colon_on_i;
            end
          end
        end
      end
      req_o.len        = 3'(FrameMax);
      req_o.two_frames = 1'b1;
    end
  end

endmodule

[design/seven_segment_two_wire_driver_top.sv]
// Top level of the two-wire seven-segment display driver.
//
// Usage:
//   s_axis carries one item per handshake: tuser holds the mode (tick, show
//   digit characters, show raw segments, set brightness), tdata the four
//   digit bytes and the colon flag. Every accepted item yields exactly one
//   result item on m_axis with the bus line levels after that item, a busy
//   flag and whether the item's request was taken.
//   A request arriving while a frame sequence runs is dropped (not taken).
//   Tick items advance the bus by one phase every phase_ticks ticks; a
//   display request sends the 0x40 frame and then 0xC0 plus the digits.
//   The cfg channel writes phase_ticks (zero acts as one); write it only
//   while idle. cfg_ready_o is always high.
// Timing:
//   The result is registered. Throughput is one item per cycle while tready
//   is high: the bus state updates in one pass of short logic at accept.
//   A result register plus a one-item skid register decouple the sides, so
//   tready stays high while a single result waits; once both hold a result
//   the input stalls until m_axis drains.
// Reset:
//   rst_ni clears the sequencer to idle with both lines high, phase_ticks
//   to one and empties the output registers.
module seven_segment_two_wire_driver_top import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cfg write channel: phase_ticks
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // byte0[7:0] byte1[15:8] byte2[23:16] byte3[31:24]
                                     // colon_on[32], zero fill [39:33]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // clk_level[0] dio_level[1] busy_res[2]
                                     // request_taken[3], zero fill [7:4]
);

  `include "assert_macros.svh"

  // Configuration
  logic [15:0] phase_ticks_q;
  logic [15:0] period;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  assign period = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;

  // Input decode
  logic       in_acc;
  mode_e      mode;
  frame_req_t req;

  assign mode   = mode_e'(s_axis_tuser);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  ssd_frame_build u_frame_build (
    .mode_i     (mode),
    .byte0_i    (s_axis_tdata[7:0]),
    .byte1_i    (s_axis_tdata[15:8]),
    .byte2_i    (s_axis_tdata[23:16]),
    .byte3_i    (s_axis_tdata[31:24]),
    .colon_on_i (s_axis_tdata[32]),
    .req_o      (req)
  );

  // Bus sequencer state
  bus_phase_e  phase_q, phase_d;
  frame_t      store_q, store_d;
  logic [2:0]  len_q, len_d;
  logic        second_q, second_d;
  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [2:0]  bit_pos_q, bit_pos_d;
  logic [15:0] prescale_q, prescale_d;
  logic        clk_line_q, clk_line_d;
  logic        dio_line_q, dio_line_d;

  logic        taken;
  logic        adv;
  logic        entering;
  logic [15:0] cnt_inc;
  logic [2:0]  cur_len;
  logic [7:0]  cur_byte;
  logic        cur_bit;

  assign cnt_inc = prescale_q + 16'd1;
  assign cur_len = second_q ? 3'd1 : len_q;

  // Next phase: tick counting, request start, phase advance.
  always_comb begin
    phase_d    = phase_q;
    store_d    = store_q;
    len_d      = len_q;
    second_d   = second_q;
    byte_pos_d = byte_pos_q;
    bit_pos_d  = bit_pos_q;
    prescale_d = prescale_q;
    taken      = 1'b0;
    adv        = 1'b0;
    if (in_acc) begin
      if (mode == MODE_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (cnt_inc >= period) begin
            adv = 1'b1;
          end else begin
            prescale_d = cnt_inc;
          end
        end
      end else if (phase_q == PH_IDLE) begin
        taken      = 1'b1;
        store_d    = req.frame;
        len_d      = req.len;
        second_d   = req.two_frames;
        byte_pos_d = 3'd0;
        bit_pos_d  = 3'd0;
        phase_d    = PH_S0;
      end
    end
    if (adv) begin
      unique case (phase_q)
        PH_S0: phase_d = PH_S1;
        PH_S1: begin
          byte_pos_d = 3'd0;
          bit_pos_d  = 3'd0;
          phase_d    = PH_B0;
        end
        PH_B0: phase_d = PH_B1;
        PH_B1: begin
          if (bit_pos_q < 3'd7) begin
            bit_pos_d = bit_pos_q + 3'd1;
            phase_d   = PH_B0;
          end else begin
            bit_pos_d = 3'd0;
            phase_d   = PH_A0;
          end
        end
        PH_A0: phase_d = PH_A1;
        PH_A1: begin
          byte_pos_d = byte_pos_q + 3'd1;
          phase_d    = (byte_pos_d < cur_len) ? PH_B0 : PH_P0;
        end
        PH_P0: phase_d = PH_P1;
        PH_P1: phase_d = PH_P2;
        PH_P2: phase_d = PH_P3;
        PH_P3: begin
          byte_pos_d = 3'd0;
          bit_pos_d  = 3'd0;
          if (second_q) begin
            second_d = 1'b0;
            phase_d  = PH_S0;
          end else begin
            phase_d  = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    entering = adv || taken;
    if (entering) begin
      prescale_d = 16'd0;
    end
  end

  // Data bit of the phase being entered.
  always_comb begin
    if (second_d) begin
      cur_byte = CmdAutoInc;
    end else if (32'(byte_pos_d) < FrameMax) begin
      cur_byte = store_q[byte_pos_d[FrameIdxW-1:0]];
    end else begin
      cur_byte = 8'd0;
    end
    cur_bit = cur_byte[bit_pos_d];
  end

  // Line levels: set when a phase begins, else hold.
  always_comb begin
    clk_line_d = clk_line_q;
    dio_line_d = dio_line_q;
    if (entering) begin
      unique case (phase_d)
        PH_S0: begin clk_line_d = 1'b1; dio_line_d = 1'b1;    end
        PH_S1: begin clk_line_d = 1'b1; dio_line_d = 1'b0;    end
        PH_B0: begin clk_line_d = 1'b0; dio_line_d = cur_bit; end
        PH_B1: begin clk_line_d = 1'b1; dio_line_d = cur_bit; end
        PH_A0: clk_line_d = 1'b0;
        PH_A1: clk_line_d = 1'b1;
        PH_P0: clk_line_d = 1'b0;
        PH_P1: begin clk_line_d = 1'b0; dio_line_d = 1'b0;    end
        PH_P2: begin clk_line_d = 1'b1; dio_line_d = 1'b0;    end
        PH_P3: begin clk_line_d = 1'b1; dio_line_d = 1'b1;    end
        default: begin clk_line_d = 1'b1; dio_line_d = 1'b1;  end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      len_q      <= 3'd0;
      second_q   <= 1'b0;
      byte_pos_q <= 3'd0;
      bit_pos_q  <= 3'd0;
      prescale_q <= 16'd0;
      clk_line_q <= 1'b1;
      dio_line_q <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      second_q   <= second_d;
      byte_pos_q <= byte_pos_d;
      bit_pos_q  <= bit_pos_d;
      prescale_q <= prescale_d;
      clk_line_q <= clk_line_d;
      dio_line_q <= dio_line_d;
    end
  end

  // Frame bytes carry no reset; every read entry is written first.
  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  // Result register with one-item skid stage
  logic [7:0] res;
  logic [7:0] out_data_q, out_data_d;
  logic [7:0] skid_data_q, skid_data_d;
  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  logic       out_acc;
  logic       out_free;

  assign res = {4'd0, taken, (phase_d != PH_IDLE), dio_line_d, clk_line_d};

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign out_free      = !out_valid_q || out_acc;

  always_comb begin
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // Input is stalled; move the waiting item up once there is room.
      if (out_free) begin
        out_data_d   = skid_data_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (out_free) begin
        out_data_d  = res;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  // Checks
  `SSD_ASSERT(a_idle_lines_high, (phase_q == PH_IDLE) |-> (clk_line_q && dio_line_q))
  `SSD_ASSERT(a_req_starts, (in_acc && (mode != MODE_TICK) && (phase_q == PH_IDLE)) |=> (phase_q == PH_S0))
  `SSD_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `SSD_ASSERT(a_idle_tick_holds, (in_acc && (mode == MODE_TICK) && (phase_q == PH_IDLE)) |=> (phase_q == PH_IDLE))

endmodule

[bench/ssd_bus_checker.sv]
`timescale 1ns / 100ps
// Checker for the two-wire display driver: predicts every result item and compares it.
module ssd_bus_checker import ssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // byte0..byte3 [31:0], colon_on [32]
  input  logic [1:0]  s_axis_tuser,  // mode [1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // clk_level [0], dio_level [1], busy_res [2],
                                     // request_taken [3]
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [7:0] AutoIncFrame  = 8'h40;
  localparam logic [7:0] AddrZeroFrame = 8'hC0;
  localparam logic [7:0] DisplayOff    = 8'h80;
  localparam logic [7:0] DisplayOn     = 8'h88;
  localparam logic [7:0] ColonSeg      = 8'h80;
  localparam logic [7:0] BrightTop     = 8'd8;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam int         DigitBytes    = 4;
  localparam int         FrameBytes    = DigitBytes + 1;

  // Segment patterns of the digits 0..9, digit 0 in the lowest byte.
  localparam logic [9:0][7:0] DigitSegments = {
    8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  typedef struct packed {
    logic request_taken;
    logic busy_res;
    logic dio_level;
    logic clk_level;
  } bus_levels_t;

  string level_names [4] = '{"clk_level", "dio_level", "busy_res", "request_taken"};

  logic [15:0] ticks_per_phase;
  logic [7:0]  frame_bytes [FrameBytes];
  logic [2:0]  frame_len;
  logic        second_pending;
  logic [2:0]  byte_pos;
  logic [2:0]  bit_pos;
  bus_phase_e  phase;
  logic [15:0] prescale;
  logic        clk_line;
  logic        dio_line;
  int          fails = 0;
  bus_levels_t expected_levels_q [$];

  function automatic logic next_bit();
    logic [7:0] b;
    b = 8'h00;
    if (second_pending) b = AutoIncFrame;
    else if (byte_pos < FrameBytes) b = frame_bytes[byte_pos];
    return b[bit_pos];
  endfunction

  // Load the line levels of a phase as it begins.
  function automatic void enter_phase(input bus_phase_e p);
    phase    = p;
    prescale = '0;
    case (p)
      PH_S0: begin clk_line = 1'b1; dio_line = 1'b1; end
      PH_S1: begin clk_line = 1'b1; dio_line = 1'b0; end
      PH_B0: begin clk_line = 1'b0; dio_line = next_bit(); end
      PH_B1: begin clk_line = 1'b1; dio_line = next_bit(); end
      PH_A0: clk_line = 1'b0;
      PH_A1: clk_line = 1'b1;
      PH_P0: clk_line = 1'b0;
      PH_P1: begin clk_line = 1'b0; dio_line = 1'b0; end
      PH_P2: begin clk_line = 1'b1; dio_line = 1'b0; end
      PH_P3: begin clk_line = 1'b1; dio_line = 1'b1; end
      default: begin phase = PH_IDLE; clk_line = 1'b1; dio_line = 1'b1; end
    endcase
  endfunction

  function automatic void advance_phase();
    case (phase)
      PH_S0: enter_phase(PH_S1);
      PH_S1: begin
        byte_pos = '0;
        bit_pos  = '0;
        enter_phase(PH_B0);
      end
      PH_B0: enter_phase(PH_B1);
      PH_B1: begin
        if (bit_pos < 3'd7) begin
          bit_pos = bit_pos + 3'd1;
          enter_phase(PH_B0);
        end else begin
          bit_pos = '0;
          enter_phase(PH_A0);
        end
      end
      PH_A0: enter_phase(PH_A1);
      PH_A1: begin
        byte_pos = byte_pos + 3'd1;
        if (byte_pos < (second_pending ? 3'd1 : frame_len)) enter_phase(PH_B0);
        else enter_phase(PH_P0);
      end
      PH_P0: enter_phase(PH_P1);
      PH_P1: enter_phase(PH_P2);
      PH_P2: enter_phase(PH_P3);
      PH_P3: begin
        byte_pos = '0;
        bit_pos  = '0;
        if (second_pending) begin
          second_pending = 1'b0;
          enter_phase(PH_S0);
        end else begin
          enter_phase(PH_IDLE);
        end
      end
      default: enter_phase(PH_IDLE);
    endcase
  endfunction

  // Apply one input item to the predicted bus state; return the levels after it.
  function automatic bus_levels_t predict_levels(input mode_e m, input logic [39:0] data);
    logic [7:0]  ch;
    logic [7:0]  seg;
    logic [7:0]  level;
    logic [15:0] period;
    bus_levels_t r;
    r = '0;
    if (m == MODE_TICK) begin
      if (phase != PH_IDLE) begin
        period   = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
        prescale = prescale + 16'd1;
        if (prescale >= period) advance_phase();
      end
    end else if (phase == PH_IDLE) begin
      r.request_taken = 1'b1;
      if (m == MODE_BRIGHT) begin
        level = data[7:0];
        if (level == 8'd0) begin
          frame_bytes[0] = DisplayOff;
        end else begin
          if (level > BrightTop) level = BrightTop;
          frame_bytes[0] = DisplayOn | (level - 8'd1);
        end
        frame_len      = 3'd1;
        second_pending = 1'b0;
      end else begin
        frame_bytes[0] = AddrZeroFrame;
        for (int i = 0; i < DigitBytes; i++) begin
          ch = data[8*i +: 8];
          if (m == MODE_RAW) begin
            seg = ch;
          end else begin
            seg = 8'h00;
            if (ch >= CharZero && ch <= CharNine) seg = DigitSegments[ch - CharZero];
            if (i == 1 && data[32]) seg = seg | ColonSeg;
          end
          frame_bytes[i+1] = seg;
        end
        frame_len      = 3'(FrameBytes);
        second_pending = 1'b1;
      end
      byte_pos = '0;
      bit_pos  = '0;
      enter_phase(PH_S0);
    end
    r.clk_level = clk_line;
    r.dio_level = dio_line;
    r.busy_res  = (phase != PH_IDLE);
    return r;
  endfunction

  always @(posedge clk_i) begin
    bus_levels_t got;
    bus_levels_t want;
    if (!rst_ni) begin
      ticks_per_phase = 16'd1;
      foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
      frame_len      = '0;
      second_pending = 1'b0;
      byte_pos       = '0;
      bit_pos        = '0;
      phase          = PH_IDLE;
      prescale       = '0;
      clk_line       = 1'b1;
      dio_line       = 1'b1;
      expected_levels_q.delete();
    end else begin
      // Retire first: a result never belongs to the item accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        got = bus_levels_t'(m_axis_tdata[3:0]);
        if (expected_levels_q.size() == 0) begin
          $error("result item %b with no item outstanding", m_axis_tdata);
          fails++;
        end else begin
          want = expected_levels_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[k] !== want[k]) begin
              $error("%s: expected %0b, actual %0b", level_names[k], want[k], got[k]);
              fails++;
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) ticks_per_phase = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_levels_q.push_back(predict_levels(mode_e'(s_axis_tuser), s_axis_tdata));
    end
    fail_count_o <= fails;
    pending_o    <= expected_levels_q.size();
  end

endmodule

[bench/seven_segment_two_wire_driver_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top of the two-wire display driver: stimulus, stall control and verdict.
module seven_segment_two_wire_driver_top_tb;
  import ssd_pkg::*;

  // Bus phases of a full display request (two frames) and of a brightness request.
  localparam int DisplayPhases = 120;
  localparam int BrightPhases  = 24;
  localparam int CycleLimit    = 3_000_000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = MODE_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int          fail_count;
  int          pending;
  bit          gaps_on = 1'b1;  // random idling on both sides when set
  int          sink_wait = 0;
  int unsigned ticks_now = 1;   // effective ticks per phase currently programmed
  int          cycles = 0;

  seven_segment_two_wire_driver_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ssd_bus_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: after each accepted item draw a random wait and hold tready low until it runs down.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sink_wait = gaps_on ? $urandom_range(0, 3) : 0;
      m_axis_tready <= (sink_wait == 0);
    end else if (!m_axis_tready) begin
      if (sink_wait <= 1) m_axis_tready <= 1'b1;
      sink_wait = sink_wait - 1;
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("seven_segment_two_wire_driver_top_tb: FAIL");
    $finish;
  end

  // Present one item after a random gap and hold it until accepted. Leave tvalid
  // high on return so a back-to-back item needs no second assignment.
  task automatic send_item(input mode_e m, input logic [31:0] bytes, input logic colon);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {7'd0, colon, bytes};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Tick items carry random payload bits; the block ignores them.
  task automatic send_ticks(input int n);
    repeat (n) send_item(MODE_TICK, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Drain every outstanding result, then write ticks per phase.
  task automatic set_phase_ticks(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ticks_now = (v == 16'd0) ? 1 : v;
  endtask

  // Issue a request and tick it through to idle.
  task automatic run_request(input mode_e m, input logic [31:0] bytes, input logic colon);
    send_item(m, bytes, colon);
    send_ticks(((m == MODE_BRIGHT) ? BrightPhases : DisplayPhases) * ticks_now);
  endtask

  // Payload for a well-formed request: lean toward digit characters and small
  // brightness values so the interesting encodings come up often.
  function automatic logic [31:0] random_payload(input mode_e m);
    logic [31:0] p;
    p = $urandom;
    if (m == MODE_DIGITS) begin
      for (int i = 0; i < 4; i++)
        if ($urandom_range(0, 1)) p[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
    end else if (m == MODE_BRIGHT && $urandom_range(0, 1)) begin
      p[7:0] = 8'($urandom_range(0, 10));
    end
    return p;
  endfunction

  initial begin
    mode_e m;
    int    sent;
    int    burst;
    int    phases;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at one tick per phase.
    set_phase_ticks(16'd1);
    send_ticks(2);  // ticks while idle change nothing
    run_request(MODE_BRIGHT, 32'h0000_0000, 1'b0);  // zero turns the display off
    run_request(MODE_BRIGHT, 32'hffff_ff01, 1'b1);
    run_request(MODE_BRIGHT, 32'h0000_0008, 1'b0);
    run_request(MODE_BRIGHT, 32'h0000_0009, 1'b0);  // clamp to eight
    run_request(MODE_BRIGHT, 32'h0000_00ff, 1'b0);
    // A display request, then requests while busy: those are dropped and count no tick.
    send_item(MODE_DIGITS, "3210", 1'b0);
    send_item(MODE_RAW, 32'hffff_ffff, 1'b1);
    send_item(MODE_BRIGHT, 32'h0000_0003, 1'b0);
    send_ticks(DisplayPhases);
    run_request(MODE_DIGITS, "/:98", 1'b1);          // two characters just outside 0..9, two inside

    // Widest phase: start a phase at the top setting, then lower the
    // setting mid-phase so the next tick ends it.
    set_phase_ticks(16'hffff);
    gaps_on = 1'b0;
    send_item(MODE_BRIGHT, 32'h0000_0004, 1'b0);
    send_ticks(20);
    set_phase_ticks(16'd1);
    send_ticks(BrightPhases);
    gaps_on = 1'b1;

    // Random part: mostly complete requests with random content, some cut
    // short so the next request lands while busy, and some plain noise.
    // Leave each segment wherever it stops so the setting changes mid-sequence.
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: set_phase_ticks(16'd1);
        1: set_phase_ticks(16'd0);  // zero acts as one
        2: set_phase_ticks(16'd2);
        default: set_phase_ticks(16'($urandom_range(1, 3)));
      endcase
      gaps_on = (seg != 2);  // one stretch runs without idling
      sent = 0;
      while (sent < 20) begin
        if ($urandom_range(0, 9) < 8) begin
          m = mode_e'($urandom_range(1, 3));
          send_item(m, random_payload(m), 1'($urandom_range(0, 1)));
          phases = (m == MODE_BRIGHT) ? BrightPhases : DisplayPhases;
          if ($urandom_range(0, 4) == 0) burst = $urandom_range(1, phases * ticks_now);
          else burst = phases * ticks_now + $urandom_range(0, 3);
        end else begin
          m = mode_e'($urandom_range(0, 3));
          send_item(m, $urandom, 1'($urandom_range(0, 1)));
          burst = $urandom_range(0, 6);
        end
        send_ticks(burst);
        sent += burst + 1;
      end
    end
    gaps_on = 1'b1;

    // Drain, then keep the clock running for any stray result.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("seven_segment_two_wire_driver_top_tb: PASS");
    end else begin
      $display("seven_segment_two_wire_driver_top_tb: FAIL");
    end
    $finish;
  end

endmodule
